// ===== src/fbgray_pkg.sv =====
// ----------------------------------------------------------------------------
// fbgray_pkg
// Shared types, sizes and codes of the frame buffer flip/split/gray engine.
// ----------------------------------------------------------------------------
package fbgray_pkg;

    localparam int MAX_WIDTH    = 256;
    localparam int MAX_HEIGHT   = 256;
    localparam int CHANNEL_BITS = 8;

    localparam int DEPTH     = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_BITS = $clog2(DEPTH);
    localparam int LC_BITS   = $clog2(DEPTH + 1);
    localparam int COL_BITS  = $clog2(MAX_WIDTH);
    localparam int ROW_BITS  = $clog2(MAX_HEIGHT);
    localparam int W_BITS    = $clog2(MAX_WIDTH + 1);
    localparam int H_BITS    = $clog2(MAX_HEIGHT + 1);
    localparam int SUM_BITS  = CHANNEL_BITS + 2;

    // floor(x / 3) for x < 3 * 2**CHANNEL_BITS as (x * GRAY_MUL) >> GRAY_SHIFT
    localparam int GRAY_SHIFT = CHANNEL_BITS + 3;
    localparam int GRAY_MUL   = (2 ** GRAY_SHIFT) / 3 + 1;

    localparam int CFG_BITS     = 9;
    localparam int CFG_IDX_BITS = 2;

    localparam logic [CFG_IDX_BITS-1:0] CFG_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_MODE   = 2'd2;

    localparam logic [2:0] MODE_GRAY     = 3'd1;
    localparam logic [2:0] MODE_MIRROR_H = 3'd2;
    localparam logic [2:0] MODE_MIRROR_V = 3'd3;
    localparam logic [2:0] MODE_SPLIT_LR = 3'd4;
    localparam logic [2:0] MODE_SPLIT_TB = 3'd5;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_FETCH = 1'b1;

    typedef struct packed {
        logic       opcode;
        logic [7:0] red_in;
        logic [7:0] green_in;
        logic [7:0] blue_in;
    } in_item_t;

    typedef struct packed {
        logic [7:0] red_out;
        logic [7:0] green_out;
        logic [7:0] blue_out;
        logic       part_index;
        logic       last_in_part;
        logic       past_end;
    } out_item_t;

    typedef struct packed {
        logic [CHANNEL_BITS-1:0] r;
        logic [CHANNEL_BITS-1:0] g;
        logic [CHANNEL_BITS-1:0] b;
    } pix_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_POS,
        ST_ADDR,
        ST_READ,
        ST_SUM,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic capture;
        logic load_write;
        logic pos_step;
        logic addr_step;
        logic read_step;
        logic sum_step;
        logic out_load;
    } cmd_t;

endpackage

// ===== src/frame_buffer_flip_split_gray_core.sv =====
// ----------------------------------------------------------------------------
// frame_buffer_flip_split_gray_core
// Frame buffer engine: loads RGB pixels in raster order, fetches them back
// gray, mirrored or split by halves.
// ----------------------------------------------------------------------------
// channel   direction  handshake          payload
// s_        in         s_valid/s_ready    in_item_t (opcode, rgb)
// m_        out        m_valid/m_ready    out_item_t (rgb, part, last, past_end)
// cfg_      in         cfg_we             cfg_index, cfg_data
//
// Load steps: accept, store write. Fetch steps: accept, cursor, address
// multiply, store read, channel sum, gray scale into result register.
// One item at a time through the single store port; a new item is taken
// while a result waits in the output register, a fetch stalls only at its
// last step until that register frees. Synchronous reset, no clearing pass.
// ----------------------------------------------------------------------------
module frame_buffer_flip_split_gray_core (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_we,
    input  logic [fbgray_pkg::CFG_IDX_BITS-1:0] cfg_index,
    input  logic [fbgray_pkg::CFG_BITS-1:0]     cfg_data,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  fbgray_pkg::in_item_t                s_payload,
    output logic                                m_valid,
    input  logic                                m_ready,
    output fbgray_pkg::out_item_t               m_payload
);

    fbgray_pkg::cmd_t cmd;

    fbgray_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .opcode  (s_payload.opcode),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd)
    );

    fbgray_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_payload (s_payload),
        .cmd       (cmd),
        .m_payload (m_payload)
    );

endmodule

// ===== src/fbgray_ctrl.sv =====
// ----------------------------------------------------------------------------
// fbgray_ctrl
// Sequencer: accepts items, steps the datapath, owns the result valid flag.
// ----------------------------------------------------------------------------
module fbgray_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               opcode,
    output logic               m_valid,
    input  logic               m_ready,
    output fbgray_pkg::cmd_t   cmd
);

    fbgray_pkg::state_t state_reg, state_next;
    logic               m_valid_reg, m_valid_next;
    logic               out_free;

    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == fbgray_pkg::ST_IDLE);
    assign m_valid  = m_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= fbgray_pkg::ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg && !m_ready;
        cmd          = '0;
        unique case (state_reg)
            fbgray_pkg::ST_IDLE: begin
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    state_next  = (opcode == fbgray_pkg::OP_FETCH) ?
                                  fbgray_pkg::ST_POS : fbgray_pkg::ST_LOAD;
                end
            end
            fbgray_pkg::ST_LOAD: begin
                cmd.load_write = 1'b1;
                state_next     = fbgray_pkg::ST_IDLE;
            end
            fbgray_pkg::ST_POS: begin
                cmd.pos_step = 1'b1;
                state_next   = fbgray_pkg::ST_ADDR;
            end
            fbgray_pkg::ST_ADDR: begin
                cmd.addr_step = 1'b1;
                state_next    = fbgray_pkg::ST_READ;
            end
            fbgray_pkg::ST_READ: begin
                cmd.read_step = 1'b1;
                state_next    = fbgray_pkg::ST_SUM;
            end
            fbgray_pkg::ST_SUM: begin
                cmd.sum_step = 1'b1;
                state_next   = fbgray_pkg::ST_OUT;
            end
            fbgray_pkg::ST_OUT: begin
                if (out_free) begin
                    cmd.out_load = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = fbgray_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = fbgray_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// ===== src/fbgray_dp.sv =====
// ----------------------------------------------------------------------------
// fbgray_dp
// Datapath: config registers, pixel store, output cursor, address and gray
// arithmetic, result register.
// ----------------------------------------------------------------------------
module fbgray_dp (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_we,
    input  logic [fbgray_pkg::CFG_IDX_BITS-1:0] cfg_index,
    input  logic [fbgray_pkg::CFG_BITS-1:0]     cfg_data,
    input  fbgray_pkg::in_item_t               s_payload,
    input  fbgray_pkg::cmd_t                   cmd,
    output fbgray_pkg::out_item_t              m_payload
);

    localparam int ROW_BITS  = fbgray_pkg::ROW_BITS;
    localparam int COL_BITS  = fbgray_pkg::COL_BITS;
    localparam int W_BITS    = fbgray_pkg::W_BITS;
    localparam int H_BITS    = fbgray_pkg::H_BITS;
    localparam int LC_BITS   = fbgray_pkg::LC_BITS;
    localparam int ADDR_BITS = fbgray_pkg::ADDR_BITS;
    localparam int CH        = fbgray_pkg::CHANNEL_BITS;
    localparam int SUM_BITS  = fbgray_pkg::SUM_BITS;
    localparam int AF_BITS   = ROW_BITS + W_BITS;
    localparam int GP_BITS   = SUM_BITS + fbgray_pkg::GRAY_SHIFT;

    logic [fbgray_pkg::CFG_BITS-1:0] width_reg, height_reg;
    logic [2:0]                      mode_reg;

    logic [LC_BITS-1:0]  load_count_reg;
    logic [ROW_BITS-1:0] row_reg;
    logic [COL_BITS-1:0] col_reg;
    logic                part_reg, finished_reg;

    fbgray_pkg::pix_t    pix_in_reg, rd_reg;
    fbgray_pkg::pix_t    mem [fbgray_pkg::DEPTH];

    logic [ROW_BITS-1:0]  sr_reg;
    logic [COL_BITS-1:0]  sc_reg;
    logic                 part_o_reg, last_reg, pe_reg, gray_reg;
    logic [ADDR_BITS-1:0] addr_reg;
    logic [SUM_BITS-1:0]  sum_reg;
    fbgray_pkg::out_item_t out_reg;

    logic [W_BITS-1:0]   w_eff, half_w, pw, col_inc;
    logic [H_BITS-1:0]   h_eff, half_h, ph, row_inc;
    logic                empty_first, part_eff, split, mode_ok, pe;
    logic [COL_BITS-1:0] col_eff, sc;
    logic [ROW_BITS-1:0] row_eff, sr;
    logic                last, wrap_col, wrap_row;
    logic [LC_BITS-1:0]  total;
    logic [AF_BITS-1:0]  addr_full;
    logic [GP_BITS-1:0]  gray_prod;
    logic [CH-1:0]       gray;

    always_comb begin
        if (width_reg == '0) begin
            w_eff = W_BITS'(1);
        end else if (int'(width_reg) > fbgray_pkg::MAX_WIDTH) begin
            w_eff = W_BITS'(fbgray_pkg::MAX_WIDTH);
        end else begin
            w_eff = W_BITS'(width_reg);
        end
        if (height_reg == '0) begin
            h_eff = H_BITS'(1);
        end else if (int'(height_reg) > fbgray_pkg::MAX_HEIGHT) begin
            h_eff = H_BITS'(fbgray_pkg::MAX_HEIGHT);
        end else begin
            h_eff = H_BITS'(height_reg);
        end
    end

    assign half_w  = w_eff >> 1;
    assign half_h  = h_eff >> 1;
    assign mode_ok = (mode_reg >= fbgray_pkg::MODE_GRAY) &&
                     (mode_reg <= fbgray_pkg::MODE_SPLIT_TB);
    assign split   = (mode_reg == fbgray_pkg::MODE_SPLIT_LR) ||
                     (mode_reg == fbgray_pkg::MODE_SPLIT_TB);
    assign pe      = finished_reg || !mode_ok;

    // first half is empty when the split dimension is 1
    assign empty_first = !part_reg &&
        (((mode_reg == fbgray_pkg::MODE_SPLIT_LR) && (half_w == '0)) ||
         ((mode_reg == fbgray_pkg::MODE_SPLIT_TB) && (half_h == '0)));
    assign part_eff = part_reg || empty_first;
    assign col_eff  = empty_first ? '0 : col_reg;
    assign row_eff  = empty_first ? '0 : row_reg;

    always_comb begin
        pw = w_eff;
        ph = h_eff;
        sc = col_eff;
        sr = row_eff;
        case (mode_reg)
            fbgray_pkg::MODE_MIRROR_H: begin
                sc = COL_BITS'(w_eff - W_BITS'(1) - W_BITS'(col_eff));
            end
            fbgray_pkg::MODE_MIRROR_V: begin
                sr = ROW_BITS'(h_eff - H_BITS'(1) - H_BITS'(row_eff));
            end
            fbgray_pkg::MODE_SPLIT_LR: begin
                pw = part_eff ? (w_eff - half_w) : half_w;
                if (part_eff) begin
                    sc = COL_BITS'(W_BITS'(col_eff) + half_w);
                end
            end
            fbgray_pkg::MODE_SPLIT_TB: begin
                ph = part_eff ? (h_eff - half_h) : half_h;
                if (part_eff) begin
                    sr = ROW_BITS'(H_BITS'(row_eff) + half_h);
                end
            end
            default: begin
            end
        endcase
    end

    assign col_inc  = W_BITS'(col_eff) + W_BITS'(1);
    assign row_inc  = H_BITS'(row_eff) + H_BITS'(1);
    assign wrap_col = (col_inc >= pw);
    assign wrap_row = (row_inc >= ph);
    assign last     = (col_inc == pw) && (row_inc == ph);

    assign total     = LC_BITS'(w_eff) * LC_BITS'(h_eff);
    assign addr_full = AF_BITS'(sr_reg) * AF_BITS'(w_eff) + AF_BITS'(sc_reg);
    assign gray_prod = GP_BITS'(sum_reg) * GP_BITS'(fbgray_pkg::GRAY_MUL);
    assign gray      = CH'(gray_prod >> fbgray_pkg::GRAY_SHIFT);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg      <= fbgray_pkg::CFG_BITS'(256);
            height_reg     <= fbgray_pkg::CFG_BITS'(256);
            mode_reg       <= fbgray_pkg::MODE_GRAY;
            load_count_reg <= '0;
            row_reg        <= '0;
            col_reg        <= '0;
            part_reg       <= 1'b0;
            finished_reg   <= 1'b0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                fbgray_pkg::CFG_WIDTH: begin
                    width_reg      <= cfg_data;
                    load_count_reg <= '0;
                end
                fbgray_pkg::CFG_HEIGHT: begin
                    height_reg     <= cfg_data;
                    load_count_reg <= '0;
                end
                fbgray_pkg::CFG_MODE: begin
                    mode_reg <= cfg_data[2:0];
                end
                default: begin
                end
            endcase
            if (cfg_index == fbgray_pkg::CFG_WIDTH ||
                cfg_index == fbgray_pkg::CFG_HEIGHT ||
                cfg_index == fbgray_pkg::CFG_MODE) begin
                row_reg      <= '0;
                col_reg      <= '0;
                part_reg     <= 1'b0;
                finished_reg <= 1'b0;
            end
        end else begin
            if (cmd.load_write && (load_count_reg < total)) begin
                load_count_reg <= load_count_reg + LC_BITS'(1);
            end
            if (cmd.pos_step && !pe) begin
                part_reg <= part_eff;
                if (wrap_col) begin
                    col_reg <= '0;
                    if (wrap_row) begin
                        row_reg <= '0;
                        if (split && !part_eff) begin
                            part_reg <= 1'b1;
                        end else begin
                            finished_reg <= 1'b1;
                        end
                    end else begin
                        row_reg <= ROW_BITS'(row_inc);
                    end
                end else begin
                    col_reg <= COL_BITS'(col_inc);
                    row_reg <= row_eff;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            pix_in_reg.r <= CH'(s_payload.red_in);
            pix_in_reg.g <= CH'(s_payload.green_in);
            pix_in_reg.b <= CH'(s_payload.blue_in);
        end
        if (cmd.load_write && (load_count_reg < total)) begin
            mem[load_count_reg[ADDR_BITS-1:0]] <= pix_in_reg;
        end
        if (cmd.read_step) begin
            rd_reg <= mem[addr_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.pos_step) begin
            sr_reg     <= sr;
            sc_reg     <= sc;
            part_o_reg <= part_eff;
            last_reg   <= last;
            pe_reg     <= pe;
            gray_reg   <= (mode_reg == fbgray_pkg::MODE_GRAY);
        end
        if (cmd.addr_step) begin
            addr_reg <= addr_full[ADDR_BITS-1:0];
        end
        if (cmd.sum_step) begin
            sum_reg <= SUM_BITS'(rd_reg.r) + SUM_BITS'(rd_reg.g) + SUM_BITS'(rd_reg.b);
        end
        if (cmd.out_load) begin
            if (pe_reg) begin
                out_reg.red_out      <= '0;
                out_reg.green_out    <= '0;
                out_reg.blue_out     <= '0;
                out_reg.part_index   <= 1'b0;
                out_reg.last_in_part <= 1'b0;
                out_reg.past_end     <= 1'b1;
            end else begin
                out_reg.red_out      <= 8'(gray_reg ? gray : rd_reg.r);
                out_reg.green_out    <= 8'(gray_reg ? gray : rd_reg.g);
                out_reg.blue_out     <= 8'(gray_reg ? gray : rd_reg.b);
                out_reg.part_index   <= part_o_reg;
                out_reg.last_in_part <= last_reg;
                out_reg.past_end     <= 1'b0;
            end
        end
    end

    assign m_payload = out_reg;

endmodule
